/* rtl/mqd_pkg.sv */
// Shared types, codes and defaults for the MQTT receive deframer.
package mqd_pkg;

   localparam int unsigned LENGTH_BYTES_DEFAULT = 4;
   localparam int unsigned LEN_CNT_W = 3;
   localparam int unsigned REM_W = 28;
   localparam logic [REM_W-1:0] MAX_PUBLISH_RESET = 28'd8192;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_TOPIC   = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_DISCARD = 2'd3;

   localparam logic [3:0] ST_NONE        = 4'd0;
   localparam logic [3:0] ST_DELIVERED   = 4'd1;
   localparam logic [3:0] ST_PINGRESP    = 4'd2;
   localparam logic [3:0] ST_SUB_GRANTED = 4'd3;
   localparam logic [3:0] ST_SUB_REJECT  = 4'd4;
   localparam logic [3:0] ST_PUB_LEN_BAD = 4'd5;
   localparam logic [3:0] ST_TOPIC_BAD   = 4'd6;
   localparam logic [3:0] ST_UNKNOWN     = 4'd7;
   localparam logic [3:0] ST_MALFORMED   = 4'd8;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [1:0]       kind;
      logic             packet_end;
      logic [3:0]       status;
      logic [15:0]      topic_length;
      logic [REM_W-1:0] payload_length;
      logic [7:0]       ack_code;
      logic [1:0]       qos_level;
   } result_type;

endpackage

/* rtl/mqd_parse.sv */
// Packet parse state machine: tags one byte per step and tracks packet state.
module mqd_parse #(
   parameter int unsigned LENGTH_BYTES = mqd_pkg::LENGTH_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    rx_byte,
   input  logic [mqd_pkg::REM_W-1:0]     max_len,
   output mqd_pkg::result_type           result
);

   typedef enum logic [3:0] {
      PH_TYPE     = 4'd0,
      PH_LEN      = 4'd1,
      PH_TLEN_HI  = 4'd2,
      PH_TLEN_LO  = 4'd3,
      PH_TOPIC    = 4'd4,
      PH_PKTID    = 4'd5,
      PH_PAYLOAD  = 4'd6,
      PH_SUBACK   = 4'd7,
      PH_DRAIN_PL = 4'd8,
      PH_DRAIN_TL = 4'd9,
      PH_DRAIN_PR = 4'd10,
      PH_DRAIN_UN = 4'd11
   } phase_type;

   phase_type                        phase_ff, phase_in;
   logic [7:0]                       header_ff, header_in;
   logic [mqd_pkg::REM_W-1:0]        acc_ff, acc_in;
   logic [mqd_pkg::LEN_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [mqd_pkg::REM_W-1:0]        left_ff, left_in;
   logic [15:0]                      tlen_ff, tlen_in;
   logic [15:0]                      fcnt_ff, fcnt_in;
   logic [7:0]                       ack_ff, ack_in;

   logic [mqd_pkg::REM_W-1:0]        left_dec;
   logic [mqd_pkg::REM_W-1:0]        len_part;
   logic [15:0]                      tlen_new;
   logic [16:0]                      need;
   logic [3:0]                       disp_status;
   logic [3:0]                       done_status;
   logic                             is_pub;
   logic                             has_qos;

   assign is_pub   = (header_ff[7:4] == 4'h3);
   assign has_qos  = is_pub && (header_ff[2:1] != 2'd0);
   assign left_dec = (left_ff != '0) ? left_ff - 28'd1 : left_ff;
   assign tlen_new = {tlen_ff[15:8], rx_byte};
   assign need     = {1'b0, tlen_new} + (has_qos ? 17'd2 : 17'd0);

   always_comb begin
      case (cnt_ff[1:0])
         2'd0: len_part = {21'd0, rx_byte[6:0]};
         2'd1: len_part = {14'd0, rx_byte[6:0], 7'd0};
         2'd2: len_part = {7'd0, rx_byte[6:0], 14'd0};
         default: len_part = {rx_byte[6:0], 21'd0};
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      header_in   = header_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      left_in     = left_ff;
      tlen_in     = tlen_ff;
      fcnt_in     = fcnt_ff;
      ack_in      = ack_ff;
      disp_status = mqd_pkg::ST_NONE;
      done_status = mqd_pkg::ST_NONE;
      result.data_byte      = rx_byte;
      result.kind           = mqd_pkg::KIND_HEADER;
      result.packet_end     = 1'b0;
      result.status         = mqd_pkg::ST_NONE;
      result.payload_length = '0;

      unique case (phase_ff)
         PH_TYPE: begin
            header_in = rx_byte;
            acc_in    = '0;
            cnt_in    = '0;
            left_in   = '0;
            tlen_in   = '0;
            fcnt_in   = '0;
            ack_in    = 8'hFF;
            phase_in  = PH_LEN;
         end
         PH_LEN: begin
            acc_in = acc_ff | len_part;
            cnt_in = cnt_ff + 3'd1;
            if (rx_byte[7]) begin
               if (cnt_in >= mqd_pkg::LEN_CNT_W'(LENGTH_BYTES)) begin
                  result.packet_end = 1'b1;
                  result.status     = mqd_pkg::ST_MALFORMED;
                  phase_in          = PH_TYPE;
               end
            end else begin
               left_in = acc_in;
               fcnt_in = '0;
               if (is_pub) begin
                  if (acc_in < 28'd2 || acc_in > max_len) begin
                     phase_in = PH_DRAIN_PL;
                     if (acc_in == '0) disp_status = mqd_pkg::ST_PUB_LEN_BAD;
                  end else begin
                     phase_in = PH_TLEN_HI;
                  end
               end else if (header_ff == 8'hD0) begin
                  phase_in = PH_DRAIN_PR;
                  if (acc_in == '0) disp_status = mqd_pkg::ST_PINGRESP;
               end else if (header_ff[7:4] == 4'h9) begin
                  phase_in = PH_SUBACK;
                  if (acc_in == '0) begin
                     disp_status = (ack_ff == 8'h80) ? mqd_pkg::ST_SUB_REJECT
                                                     : mqd_pkg::ST_SUB_GRANTED;
                  end
               end else begin
                  phase_in = PH_DRAIN_UN;
                  if (acc_in == '0) disp_status = mqd_pkg::ST_UNKNOWN;
               end
               if (disp_status != mqd_pkg::ST_NONE) begin
                  result.packet_end = 1'b1;
                  result.status     = disp_status;
                  phase_in          = PH_TYPE;
               end
            end
         end
         default: begin
            left_in = left_dec;
            case (phase_ff)
               PH_TLEN_HI: begin
                  tlen_in  = {rx_byte, 8'd0};
                  phase_in = PH_TLEN_LO;
               end
               PH_TLEN_LO: begin
                  tlen_in = tlen_new;
                  if ({11'd0, need} > left_dec) begin
                     phase_in    = PH_DRAIN_TL;
                     done_status = mqd_pkg::ST_TOPIC_BAD;
                  end else begin
                     acc_in  = left_dec - mqd_pkg::REM_W'(need);
                     fcnt_in = '0;
                     if (tlen_new != '0) begin
                        phase_in = PH_TOPIC;
                     end else begin
                        phase_in = has_qos ? PH_PKTID : PH_PAYLOAD;
                     end
                     done_status = mqd_pkg::ST_DELIVERED;
                  end
               end
               PH_TOPIC: begin
                  result.kind = mqd_pkg::KIND_TOPIC;
                  fcnt_in     = fcnt_ff + 16'd1;
                  if (fcnt_in >= tlen_ff) begin
                     fcnt_in  = '0;
                     phase_in = has_qos ? PH_PKTID : PH_PAYLOAD;
                  end
                  done_status = mqd_pkg::ST_DELIVERED;
               end
               PH_PKTID: begin
                  fcnt_in = fcnt_ff + 16'd1;
                  if (fcnt_in >= 16'd2) phase_in = PH_PAYLOAD;
                  done_status = mqd_pkg::ST_DELIVERED;
               end
               PH_PAYLOAD: begin
                  result.kind = mqd_pkg::KIND_PAYLOAD;
                  done_status = mqd_pkg::ST_DELIVERED;
               end
               PH_SUBACK: begin
                  if (fcnt_ff == 16'd2) ack_in = rx_byte;
                  if (fcnt_ff != 16'hFFFF) fcnt_in = fcnt_ff + 16'd1;
                  done_status = (ack_in == 8'h80) ? mqd_pkg::ST_SUB_REJECT
                                                  : mqd_pkg::ST_SUB_GRANTED;
               end
               PH_DRAIN_PL: begin
                  result.kind = mqd_pkg::KIND_DISCARD;
                  done_status = mqd_pkg::ST_PUB_LEN_BAD;
               end
               PH_DRAIN_TL: begin
                  result.kind = mqd_pkg::KIND_DISCARD;
                  done_status = mqd_pkg::ST_TOPIC_BAD;
               end
               PH_DRAIN_PR: begin
                  result.kind = mqd_pkg::KIND_DISCARD;
                  done_status = mqd_pkg::ST_PINGRESP;
               end
               default: begin
                  result.kind = mqd_pkg::KIND_DISCARD;
                  done_status = mqd_pkg::ST_UNKNOWN;
               end
            endcase
            if (left_dec == '0) begin
               result.packet_end = 1'b1;
               result.status     = done_status;
               if (done_status == mqd_pkg::ST_DELIVERED) result.payload_length = acc_in;
               phase_in = PH_TYPE;
            end
         end
      endcase

      result.topic_length = tlen_in;
      result.ack_code     = ack_in;
      result.qos_level    = (header_in[7:4] == 4'h3) ? header_in[2:1] : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         header_ff <= '0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
         left_ff   <= '0;
         tlen_ff   <= '0;
         fcnt_ff   <= '0;
         ack_ff    <= 8'hFF;
      end else if (step) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
         left_ff   <= left_in;
         tlen_ff   <= tlen_in;
         fcnt_ff   <= fcnt_in;
         ack_ff    <= ack_in;
      end
   end

endmodule

/* rtl/mqtt_rx_packet_deframer.sv */
// Top level of the MQTT receive deframer: word registers, handshakes, config.
// Usage:
//  req_ channel: one received byte per word (req_rx_byte), valid/ready.
//  rsp_ channel: one tagged word per accepted byte: byte, kind, packet_end,
//    status, topic_length, payload_length, ack_code, qos_level.
//  csr_ channel: writes max_publish_length; always ready. It must be written only
//    while idle, by the user; the block does not enforce this.
//  Path: an accepted req_ word sits in the input register, then the parser logic
//    feeds the result register; one word per cycle while rsp_ready is high.
//  Stall: while rsp_ready is low the result register holds, the input register
//    holds its word, and req_ready drops once both are full; nothing is lost.
//  Reset: synchronous; both registers empty, parser waits for a type byte,
//    max_publish_length returns to 8192.
module mqtt_rx_packet_deframer #(
   parameter int unsigned LENGTH_BYTES = mqd_pkg::LENGTH_BYTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_data_byte,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_packet_end,
   output logic [3:0]                 rsp_status,
   output logic [15:0]                rsp_topic_length,
   output logic [mqd_pkg::REM_W-1:0]  rsp_payload_length,
   output logic [7:0]                 rsp_ack_code,
   output logic [1:0]                 rsp_qos_level,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mqd_pkg::REM_W-1:0]  csr_max_publish_length
);

   logic                       in_valid_ff;
   logic [7:0]                 in_byte_ff;
   logic                       out_valid_ff;
   mqd_pkg::result_type        out_ff;
   mqd_pkg::result_type        result_in;
   logic [mqd_pkg::REM_W-1:0]  max_len_ff;
   logic                       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   mqd_parse #(
      .LENGTH_BYTES(LENGTH_BYTES)
   ) u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .max_len (max_len_ff),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= mqd_pkg::MAX_PUBLISH_RESET;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) max_len_ff <= csr_max_publish_length;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_byte_ff <= req_rx_byte;
      if (advance) out_ff <= result_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_data_byte      = out_ff.data_byte;
   assign rsp_kind           = out_ff.kind;
   assign rsp_packet_end     = out_ff.packet_end;
   assign rsp_status         = out_ff.status;
   assign rsp_topic_length   = out_ff.topic_length;
   assign rsp_payload_length = out_ff.payload_length;
   assign rsp_ack_code       = out_ff.ack_code;
   assign rsp_qos_level      = out_ff.qos_level;

endmodule

/* dv/mqd_tag_checker.sv */
// Checker for the MQTT receive deframer: tracks the parse, predicts each tagged word, compares.
module mqd_tag_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [7:0]                req_rx_byte,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [7:0]                rsp_data_byte,
   input  logic [1:0]                rsp_kind,
   input  logic                      rsp_packet_end,
   input  logic [3:0]                rsp_status,
   input  logic [15:0]               rsp_topic_length,
   input  logic [mqd_pkg::REM_W-1:0] rsp_payload_length,
   input  logic [7:0]                rsp_ack_code,
   input  logic [1:0]                rsp_qos_level,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [mqd_pkg::REM_W-1:0] csr_max_publish_length,
   output int unsigned               fail_count,
   output int unsigned               pending_words,
   output int unsigned               checked_words,
   output int unsigned               packet_ends
);

   typedef enum logic [3:0] {
      PH_TYPE, PH_LEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_PKTID, PH_PAYLOAD,
      PH_SUBACK, PH_DRAIN_PL, PH_DRAIN_TL, PH_DRAIN_PR, PH_DRAIN_UN
   } parse_phase_type;

   parse_phase_type           phase;
   logic [7:0]                hdr_byte;
   logic [mqd_pkg::REM_W-1:0] len_accum;
   logic [2:0]                len_bytes;
   logic [mqd_pkg::REM_W-1:0] remaining;
   logic [15:0]               topic_size;
   logic [15:0]               field_cnt;
   logic [7:0]                ack_code;
   logic [mqd_pkg::REM_W-1:0] publish_limit;
   mqd_pkg::result_type       expected_words[$];
   mqd_pkg::result_type       got, want;

   function automatic logic is_publish();
      return hdr_byte[7:4] == 4'h3;
   endfunction

   function automatic logic [1:0] publish_qos();
      return is_publish() ? hdr_byte[2:1] : 2'd0;
   endfunction

   function automatic void clear_parser();
      phase = PH_TYPE;
      hdr_byte = '0;
      len_accum = '0;
      len_bytes = '0;
      remaining = '0;
      topic_size = '0;
      field_cnt = '0;
      ack_code = 8'hFF;
   endfunction

   function automatic parse_phase_type phase_after_topic();
      field_cnt = '0;
      return (publish_qos() != 2'd0) ? PH_PKTID : PH_PAYLOAD;
   endfunction

   // pick the body phase; returns a status when the packet is already over
   function automatic logic [3:0] start_body(input logic [mqd_pkg::REM_W-1:0] rem);
      remaining = rem;
      field_cnt = '0;
      if (is_publish()) begin
         if (rem < 2 || rem > publish_limit) begin
            phase = PH_DRAIN_PL;
            return (rem == 0) ? mqd_pkg::ST_PUB_LEN_BAD : mqd_pkg::ST_NONE;
         end
         phase = PH_TLEN_HI;
         return mqd_pkg::ST_NONE;
      end
      if (hdr_byte == 8'hD0) begin
         phase = PH_DRAIN_PR;
         return (rem == 0) ? mqd_pkg::ST_PINGRESP : mqd_pkg::ST_NONE;
      end
      if (hdr_byte[7:4] == 4'h9) begin
         phase = PH_SUBACK;
         return (rem == 0) ? mqd_pkg::ST_SUB_GRANTED : mqd_pkg::ST_NONE;
      end
      phase = PH_DRAIN_UN;
      return (rem == 0) ? mqd_pkg::ST_UNKNOWN : mqd_pkg::ST_NONE;
   endfunction

   function automatic mqd_pkg::result_type tag_byte(input logic [7:0] b);
      mqd_pkg::result_type r;
      parse_phase_type     cur;
      logic [3:0]          done;
      logic [3:0]          st;
      logic [31:0]         need;
      r = '0;
      r.data_byte = b;
      cur = phase;
      done = mqd_pkg::ST_NONE;
      if (cur == PH_TYPE) begin
         clear_parser();
         hdr_byte = b;
         phase = PH_LEN;
      end else if (cur == PH_LEN) begin
         len_accum = len_accum | (mqd_pkg::REM_W'(b[6:0]) << (7 * len_bytes[1:0]));
         len_bytes = len_bytes + 3'd1;
         if (b[7]) begin
            if (len_bytes >= mqd_pkg::LENGTH_BYTES_DEFAULT) begin
               r.packet_end = 1'b1;
               r.status = mqd_pkg::ST_MALFORMED;
               phase = PH_TYPE;
            end
         end else begin
            st = start_body(len_accum);
            if (st != mqd_pkg::ST_NONE) begin
               r.packet_end = 1'b1;
               phase = PH_TYPE;
               if (st == mqd_pkg::ST_SUB_GRANTED)
                  st = (ack_code == 8'h80) ? mqd_pkg::ST_SUB_REJECT
                                           : mqd_pkg::ST_SUB_GRANTED;
               r.status = st;
            end
         end
      end else begin
         if (remaining > 0)
            remaining = remaining - 1'b1;
         case (cur)
            PH_TLEN_HI: begin
               topic_size = {b, 8'h00};
               phase = PH_TLEN_LO;
            end
            PH_TLEN_LO: begin
               topic_size = {topic_size[15:8], b};
               need = 32'(topic_size) + ((publish_qos() != 2'd0) ? 32'd2 : 32'd0);
               if (need > 32'(remaining)) begin
                  phase = PH_DRAIN_TL;
                  done = mqd_pkg::ST_TOPIC_BAD;
               end else begin
                  len_accum = remaining - mqd_pkg::REM_W'(need);
                  field_cnt = '0;
                  phase = (topic_size > 0) ? PH_TOPIC : phase_after_topic();
                  done = mqd_pkg::ST_DELIVERED;
               end
            end
            PH_TOPIC: begin
               r.kind = mqd_pkg::KIND_TOPIC;
               field_cnt = field_cnt + 16'd1;
               if (field_cnt >= topic_size)
                  phase = phase_after_topic();
               done = mqd_pkg::ST_DELIVERED;
            end
            PH_PKTID: begin
               field_cnt = field_cnt + 16'd1;
               if (field_cnt >= 2)
                  phase = PH_PAYLOAD;
               done = mqd_pkg::ST_DELIVERED;
            end
            PH_PAYLOAD: begin
               r.kind = mqd_pkg::KIND_PAYLOAD;
               done = mqd_pkg::ST_DELIVERED;
            end
            PH_SUBACK: begin
               if (field_cnt == 2)
                  ack_code = b;
               if (field_cnt < 16'hFFFF)
                  field_cnt = field_cnt + 16'd1;
               done = (ack_code == 8'h80) ? mqd_pkg::ST_SUB_REJECT
                                          : mqd_pkg::ST_SUB_GRANTED;
            end
            PH_DRAIN_PL: begin
               r.kind = mqd_pkg::KIND_DISCARD;
               done = mqd_pkg::ST_PUB_LEN_BAD;
            end
            PH_DRAIN_TL: begin
               r.kind = mqd_pkg::KIND_DISCARD;
               done = mqd_pkg::ST_TOPIC_BAD;
            end
            PH_DRAIN_PR: begin
               r.kind = mqd_pkg::KIND_DISCARD;
               done = mqd_pkg::ST_PINGRESP;
            end
            default: begin
               r.kind = mqd_pkg::KIND_DISCARD;
               done = mqd_pkg::ST_UNKNOWN;
            end
         endcase
         if (remaining == 0) begin
            r.packet_end = 1'b1;
            r.status = done;
            if (done == mqd_pkg::ST_DELIVERED)
               r.payload_length = len_accum;
            phase = PH_TYPE;
         end
      end
      r.topic_length = topic_size;
      r.ack_code = ack_code;
      r.qos_level = publish_qos();
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp_val,
                                       input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("word %0d: %s expected 0x%0h, actual 0x%0h", checked_words, name,
                exp_val, act_val);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         publish_limit = mqd_pkg::MAX_PUBLISH_RESET;
         expected_words.delete();
         fail_count = 0;
         checked_words = 0;
         packet_ends = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_data_byte, rsp_kind, rsp_packet_end, rsp_status, rsp_topic_length,
                   rsp_payload_length, rsp_ack_code, rsp_qos_level};
            if (expected_words.size() == 0) begin
               $error("word with data_byte 0x%0h arrived with nothing expected",
                      rsp_data_byte);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
               check_field("kind", 32'(want.kind), 32'(got.kind));
               check_field("packet_end", 32'(want.packet_end), 32'(got.packet_end));
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("topic_length", 32'(want.topic_length),
                           32'(got.topic_length));
               check_field("payload_length", 32'(want.payload_length),
                           32'(got.payload_length));
               check_field("ack_code", 32'(want.ack_code), 32'(got.ack_code));
               check_field("qos_level", 32'(want.qos_level), 32'(got.qos_level));
               checked_words++;
               if (want.packet_end)
                  packet_ends++;
            end
         end
         if (csr_valid && csr_ready)
            publish_limit = csr_max_publish_length;
         if (req_valid && req_ready)
            expected_words.push_back(tag_byte(req_rx_byte));
      end
      pending_words = expected_words.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the MQTT receive deframer: clock, reset, byte stimulus and verdict.
module tb;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic [7:0]                 req_rx_byte;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [7:0]                 rsp_data_byte;
   logic [1:0]                 rsp_kind;
   logic                       rsp_packet_end;
   logic [3:0]                 rsp_status;
   logic [15:0]                rsp_topic_length;
   logic [mqd_pkg::REM_W-1:0]  rsp_payload_length;
   logic [7:0]                 rsp_ack_code;
   logic [1:0]                 rsp_qos_level;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [mqd_pkg::REM_W-1:0]  csr_max_publish_length;
   int unsigned                fail_count;
   int unsigned                pending_words;
   int unsigned                checked_words;
   int unsigned                packet_ends;

   int unsigned          tx_idle_pct;
   int unsigned          rx_idle_pct;
   int unsigned          bytes_sent;
   int unsigned          limit_now;
   int unsigned          limit_writes;
   int unsigned          limit_plan[7];
   int unsigned          target;
   int                   step;
   logic [7:0]           frame[$];

   mqtt_rx_packet_deframer dut (.*);
   mqd_tag_checker chk (.*);

   always #10 clock = ~clock;

   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

   task automatic send_byte(input logic [7:0] b);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame[i])
         send_byte(frame[i]);
      frame.delete();
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(input int unsigned value);
      hold_until_drained();
      csr_valid <= 1'b1;
      csr_max_publish_length <= mqd_pkg::REM_W'(value);
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      limit_now = value;
      limit_writes++;
   endtask

   task automatic add_random(input int unsigned n);
      repeat (n) frame.push_back(8'($urandom));
   endtask

   // encode a remaining length, now and then padded with redundant zero groups
   task automatic put_length(input int unsigned rem);
      int unsigned digits;
      int unsigned total;
      int unsigned i;
      logic [7:0]  d;
      digits = 1;
      while (digits < 4 && (rem >> (7 * digits)) != 0)
         digits++;
      total = ($urandom_range(0, 7) == 0) ? $urandom_range(digits, 4) : digits;
      for (i = 0; i < total; i++) begin
         d = 8'((rem >> (7 * i)) & 32'h7F);
         if (i < total - 1)
            d[7] = 1'b1;
         frame.push_back(d);
      end
   endtask

   task automatic make_random_packet();
      int unsigned sel;
      int unsigned qos;
      int unsigned tl;
      int unsigned pl;
      int unsigned tl_field;
      int unsigned rem;
      int unsigned n;
      int unsigned i;
      logic [7:0]  hdr;
      sel = $urandom_range(0, 99);
      qos = $urandom_range(0, 3);
      hdr = 8'h30 | 8'(qos << 1) | 8'($urandom_range(0, 1) << 3) | 8'($urandom_range(0, 1));
      if (sel < 58) begin
         tl = ($urandom_range(0, 59) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 8);
         pl = ($urandom_range(0, 59) == 0) ? $urandom_range(128, 300) : $urandom_range(0, 12);
         tl_field = tl;
         if (sel >= 50) begin
            tl = $urandom_range(0, 6);
            pl = $urandom_range(0, 6);
            tl_field = tl + pl + 1 +
                       (($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(0, 65000));
         end
         frame.push_back(hdr);
         put_length(2 + tl + pl + ((qos != 0) ? 2 : 0));
         frame.push_back(8'(tl_field >> 8));
         frame.push_back(8'(tl_field));
         add_random(tl + pl + ((qos != 0) ? 2 : 0));
      end else if (sel < 63) begin
         case ($urandom_range(0, 2))
            0: rem = 0;
            1: rem = 1;
            default: rem = (limit_now < 500) ? limit_now + 1 + $urandom_range(0, 2)
                                             : $urandom_range(0, 1);
         endcase
         frame.push_back(hdr);
         put_length(rem);
         add_random(rem);
      end else if (sel < 73) begin
         frame.push_back(8'h90 | 8'($urandom_range(0, 15)));
         n = $urandom_range(0, 5);
         put_length(n);
         for (i = 0; i < n; i++)
            frame.push_back((i == 2 && $urandom_range(0, 1) == 1) ? 8'h80 : 8'($urandom));
      end else if (sel < 80) begin
         hdr = ($urandom_range(0, 3) == 0) ? (8'hD0 | 8'($urandom_range(1, 15))) : 8'hD0;
         n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
         frame.push_back(hdr);
         put_length(n);
         add_random(n);
      end else if (sel < 92) begin
         do hdr = 8'($urandom); while (hdr[7:4] == 4'h3 || hdr[7:4] == 4'h9);
         n = $urandom_range(0, 6);
         frame.push_back(hdr);
         put_length(n);
         add_random(n);
      end else begin
         frame.push_back(8'($urandom));
         repeat (4) frame.push_back(8'h80 | 8'($urandom_range(0, 127)));
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_rx_byte = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_max_publish_length = '0;
      tx_idle_pct = 31;
      rx_idle_pct = 69;
      bytes_sent = 0;
      limit_writes = 0;
      limit_now = 32'(mqd_pkg::MAX_PUBLISH_RESET);
      limit_plan = '{32'(mqd_pkg::MAX_PUBLISH_RESET), 268435455, 2,
                     $urandom_range(16, 200), 0, 1, $urandom_range(300, 100000)};
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      frame = '{8'hD0, 8'h00,
                8'h90, 8'h03, 8'h00, 8'h01, 8'h80,
                8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'h30, 8'h00,
                8'h36, 8'h04, 8'h00, 8'h03, 8'h01, 8'h02,
                8'h32, 8'h05, 8'h00, 8'h00, 8'h00, 8'h07, 8'hAA,
                8'h20, 8'h00};
      send_frame();
      hold_until_drained();

      for (step = 0; step < 7; step++) begin
         tx_idle_pct = (step < 3) ? 31 : (step < 5) ? 69 : 0;
         rx_idle_pct = (step < 3) ? 69 : (step < 5) ? 31 : 0;
         if (step > 0)
            write_limit(limit_plan[step]);
         target = bytes_sent + 240;
         while (bytes_sent < target) begin
            make_random_packet();
            send_frame();
         end
      end

      hold_until_drained();
      repeat (10) @(negedge clock);
      $display("Sent %0d bytes under %0d register writes and three pacing mixes;",
               bytes_sent, limit_writes);
      $display("checked %0d tagged words covering %0d packet ends.",
               checked_words, packet_ends);
      if (fail_count == 0 && pending_words == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* mqtt_rx_packet_deframer.f */
rtl/mqd_pkg.sv
rtl/mqd_parse.sv
rtl/mqtt_rx_packet_deframer.sv
dv/mqd_tag_checker.sv
dv/tb.sv
